### hdl/twm_pkg.sv
// Shared constants, codes and types of the time window match core.
`default_nettype none

package twm_pkg;

   // Number of range cells in the scan chain.
   localparam int MAX_RANGES = 16;

   // Field widths.
   localparam int RANGE_W = 20;
   localparam int SOD_W = 17;
   localparam int DOW_W = 3;
   localparam int TIME_W = 32;
   localparam int MW_W = 12;
   localparam int MASK_W = 7;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   // Calendar constants.
   localparam int SECS_PER_DAY = 86400;
   localparam int SECS_PER_MIN = 60;
   localparam int EPOCH_WEEKDAY = 4;
   localparam int DAYS_PER_WEEK = 7;

   // Local time is at most 2**32 - 1 + 60 * 2048 seconds, so it needs 33 bits
   // and its day number fits in 16 bits.
   localparam int LOCAL_W = TIME_W + 1;
   localparam int DAY_BITS = 16;

   // Division by a day: the low seven bits of 86400 are zero, so the local time
   // is shifted right by seven and multiplied by ceil(2**36 / 675). The error of
   // that reciprocal stays below 2**10, which keeps the quotient exact for every
   // shifted time below 2**26.
   localparam int DAY_POW2_SHIFT = 7;
   localparam int DAY_RECIP_W = 27;
   localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 27'd101806633;
   localparam int DAY_RECIP_SHIFT = 36;
   localparam int DAY_PROD_W = DAY_RECIP_SHIFT + DAY_BITS;

   // Item operation codes.
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Match mode codes.
   typedef enum logic [1:0] {
      MODE_HOURS          = 2'd0,
      MODE_WEEKDAYS       = 2'd1,
      MODE_WEEKDAYS_HOURS = 2'd2,
      MODE_WEEKLY         = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_MODE   = 2'd0,
      CSR_MINUTES_WEST = 2'd1,
      CSR_WEEKDAY_MASK = 2'd2,
      CSR_RANGE_COUNT  = 2'd3
   } csr_index_type;

   // Query token that travels along the cell chain.
   typedef struct packed {
      logic               valid;
      logic               done;
      logic               hit;
      logic [RANGE_W-1:0] t;
   } token_type;

   // Table write towards one cell.
   typedef struct packed {
      logic               en;
      logic [RANGE_W-1:0] first_sec;
      logic [RANGE_W-1:0] last_sec;
   } entry_write_type;

   // Local calendar split of a query time.
   typedef struct packed {
      logic [DOW_W-1:0] dow;
      logic [SOD_W-1:0] sod;
   } day_split_type;

endpackage

`default_nettype wire

### hdl/twm_if.sv
// Handshake channel interfaces of the time window match core.
`default_nettype none

// Request channel: range loads and time queries.
interface twm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [3:0]                  entry_index;
   logic [twm_pkg::RANGE_W-1:0] range_start;
   logic [twm_pkg::RANGE_W-1:0] range_end;
   logic [twm_pkg::TIME_W-1:0]  now_seconds;

   modport source (output valid, op, entry_index, range_start, range_end, now_seconds,
                   input ready);
   modport sink (input valid, op, entry_index, range_start, range_end, now_seconds,
                 output ready);
endinterface

// Response channel: one beat per request beat.
interface twm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      matched;
   logic [twm_pkg::DOW_W-1:0] day_of_week;
   logic [twm_pkg::SOD_W-1:0] second_of_day;

   modport source (output valid, matched, day_of_week, second_of_day, input ready);
   modport sink (input valid, matched, day_of_week, second_of_day, output ready);
endinterface

// Configuration write channel.
interface twm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [twm_pkg::CSR_IDX_W-1:0]  index;
   logic [twm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/time_window_match_core.sv
// Top level of the time window match core: control, registers and cell chain.
//
// A load beat writes one (start, end) pair into the cell that its entry index
// selects and answers with an all-zero beat in the next cycle. A query beat is
// shifted to local time, split into second of day and weekday by a three-stage
// reciprocal divider, and then a token walks the row of MAX_RANGES cells, one
// cell a cycle, closing at the first range that holds the tested time or at
// the first start beyond it. Its response beat follows the divider stages and
// the cell chain; one item is worked on at a time. Ranges are expected in
// ascending start order, and entries below range_count must have been loaded
// before they are scanned.
`default_nettype none

module time_window_match_core (
   input  wire logic       clock,
   input  wire logic       reset,
   twm_req_if.sink         req_if,
   twm_rsp_if.source       rsp_if,
   twm_csr_if.sink         csr_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     match_mode_ff;
   logic [twm_pkg::MW_W-1:0]       minutes_west_ff;
   logic [twm_pkg::MASK_W-1:0]     weekday_mask_ff;
   logic [twm_pkg::COUNT_W-1:0]    range_count_ff;
   logic                           hit_ff, hit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_matched_ff, rsp_matched_in;
   logic [twm_pkg::DOW_W-1:0]      rsp_dow_ff, rsp_dow_in;
   logic [twm_pkg::SOD_W-1:0]      rsp_sod_ff, rsp_sod_in;

   logic                           req_accept;
   logic                           load_accept;
   logic                           query_accept;
   logic                           out_free;
   logic signed [18:0]             offset_secs;
   logic signed [33:0]             shifted;
   logic [twm_pkg::LOCAL_W-1:0]    local_time;
   logic                           split_done;
   twm_pkg::day_split_type         split;
   logic                           day_on;
   logic [twm_pkg::RANGE_W-1:0]    week_sec;
   twm_pkg::token_type             chain [twm_pkg::MAX_RANGES+1];
   twm_pkg::entry_write_type       cell_wr [twm_pkg::MAX_RANGES];
   logic [twm_pkg::MAX_RANGES-1:0] cell_en;

   // Handshakes.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign load_accept  = req_accept && (twm_pkg::op_type'(req_if.op) == twm_pkg::OP_LOAD);
   assign query_accept = req_accept && (twm_pkg::op_type'(req_if.op) == twm_pkg::OP_QUERY);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff   <= '0;
         minutes_west_ff <= '0;
         weekday_mask_ff <= '0;
         range_count_ff  <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (twm_pkg::csr_index_type'(csr_if.index))
            twm_pkg::CSR_MATCH_MODE: begin
               match_mode_ff <= csr_if.data[1:0];
            end
            twm_pkg::CSR_MINUTES_WEST: begin
               minutes_west_ff <= csr_if.data[twm_pkg::MW_W-1:0];
            end
            twm_pkg::CSR_WEEKDAY_MASK: begin
               weekday_mask_ff <= csr_if.data[twm_pkg::MASK_W-1:0];
            end
            twm_pkg::CSR_RANGE_COUNT: begin
               range_count_ff <= csr_if.data[twm_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Local time: subtract the zone offset in seconds and clamp at zero.
   assign offset_secs = $signed({{7{minutes_west_ff[twm_pkg::MW_W-1]}}, minutes_west_ff})
                        * 19'sd60;
   assign shifted     = $signed({2'b00, req_if.now_seconds})
                        - $signed({{15{offset_secs[18]}}, offset_secs});
   assign local_time  = shifted[33] ? '0 : shifted[twm_pkg::LOCAL_W-1:0];

   twm_day_split u_day_split (
      .clock      (clock),
      .reset      (reset),
      .start      (query_accept),
      .local_time (local_time),
      .done       (split_done),
      .split      (split)
   );

   // Token set-up: the mode decides the tested time, and weekday-only
   // decisions enter the chain already closed.
   assign day_on   = weekday_mask_ff[split.dow];
   assign week_sec = twm_pkg::RANGE_W'(split.sod)
                     + twm_pkg::RANGE_W'(twm_pkg::SECS_PER_DAY) * twm_pkg::RANGE_W'(split.dow);

   always_comb begin
      chain[0].valid = (state_ff == ST_DIVIDE) && split_done;
      chain[0].done  = 1'b0;
      chain[0].hit   = 1'b0;
      chain[0].t     = twm_pkg::RANGE_W'(split.sod);
      case (twm_pkg::mode_type'(match_mode_ff))
         twm_pkg::MODE_WEEKDAYS: begin
            chain[0].done = 1'b1;
            chain[0].hit  = day_on;
         end
         twm_pkg::MODE_WEEKDAYS_HOURS: begin
            chain[0].done = !day_on;
         end
         twm_pkg::MODE_WEEKLY: begin
            chain[0].t = week_sec;
         end
         default: begin
         end
      endcase
   end

   // Row of range cells; cells at or beyond the range count let tokens pass.
   for (genvar i = 0; i < twm_pkg::MAX_RANGES; i++) begin : g_cell
      assign cell_en[i]           = ({27'd0, range_count_ff} > 32'(i));
      assign cell_wr[i].en        = load_accept && ({28'd0, req_if.entry_index} == 32'(i));
      assign cell_wr[i].first_sec = req_if.range_start;
      assign cell_wr[i].last_sec  = req_if.range_end;

      twm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (cell_en[i]),
         .wr       (cell_wr[i]),
         .prev_tok (chain[i]),
         .next_tok (chain[i+1])
      );
   end

   // Sequencer and response register.
   always_comb begin
      state_in       = state_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_dow_in     = rsp_dow_ff;
      rsp_sod_in     = rsp_sod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_accept) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = 1'b0;
               rsp_dow_in     = '0;
               rsp_sod_in     = '0;
            end else if (query_accept) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (split_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[twm_pkg::MAX_RANGES].valid) begin
               hit_in   = chain[twm_pkg::MAX_RANGES].hit;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = hit_ff;
               rsp_dow_in     = split.dow;
               rsp_sod_in     = split.sod;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hit_ff         <= hit_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_dow_ff     <= rsp_dow_in;
      rsp_sod_ff     <= rsp_sod_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.matched       = rsp_matched_ff;
   assign rsp_if.day_of_week   = rsp_dow_ff;
   assign rsp_if.second_of_day = rsp_sod_ff;

endmodule

`default_nettype wire

### hdl/twm_day_split.sv
// Split of local time into second of day and weekday by reciprocal multiplication.
`default_nettype none

module twm_day_split (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [twm_pkg::LOCAL_W-1:0] local_time,
   output logic                             done,
   output twm_pkg::day_split_type           split
);

   logic [twm_pkg::LOCAL_W-1:0]    local_ff;
   logic [twm_pkg::DAY_BITS-1:0]   day_ff, day_in;
   twm_pkg::day_split_type         split_ff, split_in;
   logic                           stage1_ff;
   logic                           stage2_ff;
   logic                           done_ff;
   logic [twm_pkg::DAY_PROD_W-1:0] prod;
   logic [5:0]                     oct_sum;
   logic [3:0]                     oct_fold;
   logic [2:0]                     day_mod7;
   logic [3:0]                     dow_sum;

   // First stage: the day number from the reciprocal of a day.
   always_comb begin
      prod   = twm_pkg::DAY_PROD_W'(local_ff[twm_pkg::LOCAL_W-1:twm_pkg::DAY_POW2_SHIFT])
               * twm_pkg::DAY_PROD_W'(twm_pkg::DAY_RECIP);
      day_in = twm_pkg::DAY_BITS'(prod >> twm_pkg::DAY_RECIP_SHIFT);
   end

   // Second stage: the remainder needs only its low bits, since it is below a
   // day. Eight is one modulo seven, so the day number is folded by its octal
   // digits. The epoch day was a Thursday.
   always_comb begin
      oct_sum  = 6'(day_ff[2:0]) + 6'(day_ff[5:3]) + 6'(day_ff[8:6]) + 6'(day_ff[11:9])
                 + 6'(day_ff[14:12]) + 6'(day_ff[15]);
      oct_fold = 4'(oct_sum[2:0]) + 4'(oct_sum[5:3]);
      if (oct_fold >= 4'(twm_pkg::DAYS_PER_WEEK)) begin
         day_mod7 = 3'(oct_fold - 4'(twm_pkg::DAYS_PER_WEEK));
      end else begin
         day_mod7 = oct_fold[2:0];
      end
      dow_sum = {1'b0, day_mod7} + 4'(twm_pkg::EPOCH_WEEKDAY);
      if (dow_sum >= 4'(twm_pkg::DAYS_PER_WEEK)) begin
         split_in.dow = 3'(dow_sum - 4'(twm_pkg::DAYS_PER_WEEK));
      end else begin
         split_in.dow = dow_sum[2:0];
      end
      split_in.sod = local_ff[twm_pkg::SOD_W-1:0]
                     - twm_pkg::SOD_W'(day_ff) * twm_pkg::SOD_W'(twm_pkg::SECS_PER_DAY);
   end

   // Each stage holds its result until the next query starts.
   always_ff @(posedge clock) begin
      if (start) begin
         local_ff <= local_time;
      end
      if (stage1_ff) begin
         day_ff <= day_in;
      end
      if (stage2_ff) begin
         split_ff <= split_in;
      end
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
   end

   assign done  = done_ff;
   assign split = split_ff;

endmodule

`default_nettype wire

### hdl/twm_cell.sv
// One range cell: holds a table entry and tests the passing query token.
`default_nettype none

module twm_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     enable,
   input  wire twm_pkg::entry_write_type wr,
   input  wire twm_pkg::token_type       prev_tok,
   output twm_pkg::token_type            next_tok
);

   logic [twm_pkg::RANGE_W-1:0] first_ff;
   logic [twm_pkg::RANGE_W-1:0] last_ff;
   twm_pkg::token_type          tok_ff, tok_in;

   // An open token stops at the first start beyond its time, and hits when
   // the time does not pass this entry's end.
   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.valid && !prev_tok.done && enable) begin
         if (prev_tok.t < first_ff) begin
            tok_in.done = 1'b1;
            tok_in.hit  = 1'b0;
         end else if (prev_tok.t <= last_ff) begin
            tok_in.done = 1'b1;
            tok_in.hit  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         first_ff <= wr.first_sec;
         last_ff  <= wr.last_sec;
      end
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

`default_nettype wire

### dv/time_window_match_checker.sv
// Beat monitor, behavioural predictor and comparator for the time window match core.
`timescale 1ns / 1ps

module time_window_match_checker
   import twm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   twm_req_if   req_if,
   twm_rsp_if   rsp_if,
   twm_csr_if   csr_if,
   output int   error_total,
   output int   answers_pending
);

   typedef struct packed {
      logic             matched;
      logic [DOW_W-1:0] dow;
      logic [SOD_W-1:0] sod;
   } answer_type;

   // Shadow copy of the registers and the range table.
   mode_type               cur_mode;
   logic signed [MW_W-1:0] west_minutes;
   logic [MASK_W-1:0]      day_mask;
   logic [COUNT_W-1:0]     range_total;
   logic [RANGE_W-1:0]     first_sec [MAX_RANGES];
   logic [RANGE_W-1:0]     last_sec [MAX_RANGES];
   answer_type             expected_answers [$];
   int                     errors = 0;

   // Walk the table in order and give up at the first start beyond the time.
   function automatic logic range_hit(input logic [RANGE_W-1:0] t);
      int limit;
      limit = (int'(range_total) > MAX_RANGES) ? MAX_RANGES : int'(range_total);
      for (int i = 0; i < limit; i++) begin
         if (t < first_sec[i]) return 1'b0;
         if (t <= last_sec[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Shift to local time, split into weekday and second of day, then decide the match.
   function automatic answer_type predict_answer(input logic [TIME_W-1:0] now);
      longint             shifted;
      longint             day_num;
      logic [RANGE_W-1:0] week_sec;
      logic               day_on;
      answer_type         a;
      shifted = longint'({32'd0, now}) - longint'(SECS_PER_MIN) * longint'(west_minutes);
      if (shifted < 0) shifted = 0;
      day_num = shifted / SECS_PER_DAY;
      a.sod = SOD_W'(shifted % SECS_PER_DAY);
      a.dow = DOW_W'((EPOCH_WEEKDAY + day_num) % DAYS_PER_WEEK);
      day_on = day_mask[a.dow];
      week_sec = RANGE_W'(a.sod) + RANGE_W'(a.dow) * RANGE_W'(SECS_PER_DAY);
      case (cur_mode)
         MODE_HOURS:          a.matched = range_hit(RANGE_W'(a.sod));
         MODE_WEEKDAYS:       a.matched = day_on;
         MODE_WEEKDAYS_HOURS: a.matched = day_on && range_hit(RANGE_W'(a.sod));
         default:             a.matched = range_hit(week_sec);
      endcase
      return a;
   endfunction

   always @(posedge clock) begin : watch
      answer_type got;
      answer_type want;
      if (reset) begin
         cur_mode = MODE_HOURS;
         west_minutes = '0;
         day_mask = '0;
         range_total = '0;
         expected_answers.delete();
      end else begin
         // Register writes take effect for every later request beat.
         if (csr_if.valid && csr_if.ready) begin
            case (csr_index_type'(csr_if.index))
               CSR_MATCH_MODE:   cur_mode = mode_type'(csr_if.data[1:0]);
               CSR_MINUTES_WEST: west_minutes = $signed(csr_if.data);
               CSR_WEEKDAY_MASK: day_mask = csr_if.data[MASK_W-1:0];
               CSR_RANGE_COUNT:  range_total = csr_if.data[COUNT_W-1:0];
               default: ;
            endcase
         end

         // Each accepted request beat owes exactly one response beat.
         if (req_if.valid && req_if.ready) begin
            if (op_type'(req_if.op) == OP_LOAD) begin
               if (int'(req_if.entry_index) < MAX_RANGES) begin
                  first_sec[req_if.entry_index] = req_if.range_start;
                  last_sec[req_if.entry_index] = req_if.range_end;
               end
               expected_answers.push_back('0);
            end else begin
               expected_answers.push_back(predict_answer(req_if.now_seconds));
            end
         end

         // Compare each response beat with the oldest outstanding answer.
         if (rsp_if.valid && rsp_if.ready) begin
            got.matched = rsp_if.matched;
            got.dow = rsp_if.day_of_week;
            got.sod = rsp_if.second_of_day;
            if (expected_answers.size() == 0) begin
               $error("response beat with nothing outstanding: matched %0d, day_of_week %0d, second_of_day %0d",
                      got.matched, got.dow, got.sod);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               if (got.matched !== want.matched) begin
                  $error("matched: expected %0d, actual %0d", want.matched, got.matched);
                  errors++;
               end
               if (got.dow !== want.dow) begin
                  $error("day_of_week: expected %0d, actual %0d", want.dow, got.dow);
                  errors++;
               end
               if (got.sod !== want.sod) begin
                  $error("second_of_day: expected %0d, actual %0d", want.sod, got.sod);
                  errors++;
               end
            end
         end
      end
      error_total <= errors;
      answers_pending <= expected_answers.size();
   end

endmodule

### dv/time_window_match_core_test.sv
// Stimulus, clocking and final verdict for the time window match core.
`timescale 1ns / 1ps

module time_window_match_core_test;
   import twm_pkg::*;

   localparam int WEEK_SECS = DAYS_PER_WEEK * SECS_PER_DAY;
   localparam int RANDOM_PHASES = 20;
   localparam int BEATS_PER_PHASE = 40;

   logic clock = 1'b0;
   logic reset;
   logic calm;
   int   error_total;
   int   answers_pending;

   twm_req_if req_if ();
   twm_rsp_if rsp_if ();
   twm_csr_if csr_if ();

   time_window_match_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   time_window_match_checker watch (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_if          (csr_if),
      .error_total     (error_total),
      .answers_pending (answers_pending)
   );

   always #5 clock = ~clock;

   // The receiver stalls about a third of the time, except in the steady stretch.
   always @(negedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 33);
   end

   // Present one request beat, after a random gap unless calm, and hold it until it is taken.
   task automatic send_beat(input op_type op, input logic [3:0] slot,
                            input logic [RANGE_W-1:0] first, input logic [RANGE_W-1:0] last,
                            input logic [TIME_W-1:0] now);
      @(negedge clock);
      if (!calm) begin
         while ($urandom_range(0, 99) < 33) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.entry_index <= slot;
      req_if.range_start <= first;
      req_if.range_end <= last;
      req_if.now_seconds <= now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Unused payload fields carry random bits so that every bit toggles.
   task automatic load_range(input int slot, input int first, input int last);
      send_beat(OP_LOAD, 4'(slot), RANGE_W'(first), RANGE_W'(last), $urandom());
   endtask

   task automatic query_time(input logic [TIME_W-1:0] now);
      send_beat(OP_QUERY, 4'($urandom()), RANGE_W'($urandom()), RANGE_W'($urandom()), now);
   endtask

   // Drop valid and wait until every outstanding response beat has arrived.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (answers_pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Write all four registers; bits above each field are filled at random.
   task automatic configure(input mode_type mode, input int west, input int mask,
                            input int count);
      csr_write(CSR_MATCH_MODE, {10'($urandom()), mode});
      csr_write(CSR_MINUTES_WEST, CSR_DATA_W'(west));
      csr_write(CSR_WEEKDAY_MASK, {5'($urandom()), 7'(mask)});
      csr_write(CSR_RANGE_COUNT, {7'($urandom()), 5'(count)});
   endtask

   // Load every slot, normally with starts in ascending order so the scan runs deep.
   task automatic fill_table(input int span, input bit ordered);
      int starts[$];
      int spread;
      for (int i = 0; i < MAX_RANGES; i++) starts.push_back($urandom_range(0, span - 1));
      if (ordered) starts.sort();
      spread = span / (2 * MAX_RANGES);
      foreach (starts[i]) load_range(i, starts[i], starts[i] + $urandom_range(0, spread));
   endtask

   initial begin : stimulus
      mode_type mode;
      int       west;
      int       mask;
      int       count;
      int       span;
      int       first;
      bit       ordered;
      longint   stamp;

      reset = 1'b1;
      calm = 1'b0;
      req_if.valid = 1'b0;
      req_if.op = OP_LOAD;
      req_if.entry_index = '0;
      req_if.range_start = '0;
      req_if.range_end = '0;
      req_if.now_seconds = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_MATCH_MODE;
      csr_if.data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With a zero range count the scan reads nothing and cannot match.
      query_time('0);

      // Ascending table of 3000-second windows every 6000 seconds; the top slot holds all ones.
      for (int i = 0; i < MAX_RANGES - 1; i++) load_range(i, 6000 * i, 6000 * i + 2999);
      load_range(MAX_RANGES - 1, (1 << RANGE_W) - 1, (1 << RANGE_W) - 1);
      settle();

      // Inclusive end, early stop at the next start, and the largest time.
      configure(MODE_HOURS, 0, 0, MAX_RANGES);
      query_time(32'd2999);
      query_time(32'd3000);
      query_time('1);
      settle();

      // A full day's offset west pushes a small time below zero, which clamps.
      configure(MODE_HOURS, 1440, 0, MAX_RANGES);
      query_time(32'd100);
      settle();

      // A full day's offset east takes the local time past 32 bits.
      configure(MODE_HOURS, -1440, 0, MAX_RANGES);
      query_time('1);
      settle();

      // Weekend mask on a Saturday.
      configure(MODE_WEEKDAYS, 0, 7'h41, MAX_RANGES);
      query_time(2 * SECS_PER_DAY);
      settle();

      // Day enabled but the hour falls between windows.
      configure(MODE_WEEKDAYS_HOURS, 0, 7'h7F, MAX_RANGES);
      query_time(SECS_PER_DAY + 3000);
      settle();

      // Weekly ranges on a Sunday, with a count above the table size.
      configure(MODE_WEEKLY, 0, 7'h7F, 31);
      query_time(3 * SECS_PER_DAY + 100);
      settle();

      // Random phases: fresh settings and table, then mostly queries.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = mode_type'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       west = 1440;
            1:       west = -1440;
            2:       west = int'($urandom_range(0, 4095)) - 2048;
            default: west = int'($urandom_range(0, 2880)) - 1440;
         endcase
         case ($urandom_range(0, 9))
            0:       mask = 0;
            1:       mask = 127;
            default: mask = $urandom_range(0, 127);
         endcase
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, MAX_RANGES);
         if (phase == 0) begin
            mask = 0;
            count = MAX_RANGES;
         end else if (phase == 1) begin
            mask = 127;
            count = 0;
         end
         span = (mode == MODE_WEEKLY) ? WEEK_SECS : SECS_PER_DAY;
         if ($urandom_range(0, 9) == 0) span = 1 << RANGE_W;
         ordered = ($urandom_range(0, 4) != 0);

         configure(mode, west, mask, count);
         calm <= (phase == 6 || phase == 7);
         fill_table(span, ordered);

         repeat (BEATS_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0: query_time($urandom_range(0, 2 * SECS_PER_DAY));
               1: begin
                  // Either side of a local midnight.
                  stamp = longint'($urandom_range(0, 49710)) * SECS_PER_DAY + 60 * west
                          - longint'($urandom_range(0, 1));
                  query_time(TIME_W'(stamp));
               end
               2: begin
                  first = $urandom_range(0, span - 1);
                  load_range($urandom_range(0, MAX_RANGES - 1), first,
                             first + $urandom_range(0, span / 16));
               end
               default: query_time($urandom());
            endcase
         end
         settle();
      end

      repeat (100) @(posedge clock);
      if (error_total == 0 && answers_pending == 0) begin
         $display("[time_window_match_core] OK");
      end else begin
         $display("[time_window_match_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("[time_window_match_core] ERROR");
      $finish;
   end

endmodule
